### src/rfrl_pkg.sv
// Shared types and constants for the ring FIFO linear resampler.
// Used by rfrl_interp and ring_fifo_linear_resampler_unit.
package rfrl_pkg;

    // Default sizes
    localparam int DEF_STORE_DEPTH     = 4096;
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_PHASE_FRAC_BITS = 16;

    // Nominal rates that set the phase step after reset (source / output)
    localparam int SRC_RATE_HZ = 12000;
    localparam int OUT_RATE_HZ = 48000;

    // Steering from the sequencer to the interpolation datapath
    typedef struct packed {
        logic load_diff;   // capture next - held
        logic use_held;    // store empty: next equals held, difference is zero
        logic load_prod;   // capture difference * phase fraction
    } interp_ctrl_t;

endpackage

### src/rfrl_store.sv
// Sample ring memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module rfrl_store #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = $clog2(STORE_DEPTH)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/rfrl_interp.sv
// Interpolation datapath: difference, registered product, floor shift and add.
// Depends on rfrl_pkg for interp_ctrl_t.
module rfrl_interp #(
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  rfrl_pkg::interp_ctrl_t         ctrl,
    input  logic signed [SAMPLE_BITS-1:0]  next_sample,
    input  logic signed [SAMPLE_BITS-1:0]  held_sample,
    input  logic [PHASE_FRAC_BITS-1:0]     phase_frac,
    output logic signed [SAMPLE_BITS-1:0]  result
);
    import rfrl_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + PHASE_FRAC_BITS + 1;

    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [DIFF_W-1:0]  prod_scaled;
    logic signed [DIFF_W-1:0]  sum;

    // Difference; zero when the store is empty
    assign diff_next = ctrl.use_held ? '0
                     : (DIFF_W'(next_sample) - DIFF_W'(held_sample));

    // Signed difference times unsigned fraction
    assign prod_next = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, phase_frac}));

    always_ff @(posedge clk)
    begin
        if (ctrl.load_diff)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // Arithmetic shift gives floor; the sum always lies between held and next
    assign prod_scaled = prod_reg[PHASE_FRAC_BITS +: DIFF_W];
    assign sum         = DIFF_W'(held_sample) + prod_scaled;
    assign result      = sum[SAMPLE_BITS-1:0];

endmodule

### src/ring_fifo_linear_resampler_unit.sv
// Top level of the ring FIFO linear resampler: sequencer, indexes, output word.
// Depends on rfrl_pkg, rfrl_store and rfrl_interp.
//
// Usage
//   Source channel (src_valid / src_stall): one word per item. mode 0 pushes
//   sample_in into the ring; mode 1 is an output tick. A push into a full ring
//   (STORE_DEPTH-1 samples) drops the oldest sample.
//   Result channel (res_valid / res_stall): one word, sample_out, per tick;
//   pushes give none. A finished word sits in an output register, so pushes
//   are still taken while the receiver stalls; a tick then waits for the slot.
//   Configuration: cfg_wr_en writes cfg_wr_data into phase_step (Q2.16);
//   the user must write only while the block is idle, not enforced by the block.
// Timing
//   A push is taken in the idle state. A tick first enters S_STEP, which
//   issues a read of the ring memory read port; each of the n (0 to 4)
//   consumed samples then takes S_CONSUME, an update, and S_STEP again. The
//   last read is the peek; S_PEEK takes the difference, S_MUL the product and
//   S_OUT the add, waiting for a free output slot. src_stall is high for the whole of a tick.
// Reset
//   Indexes, held sample and phase clear to zero; phase_step returns to
//   12000/48000. Ring contents are undefined until written; no clearing pass.
module ring_fifo_linear_resampler_unit #(
    parameter int STORE_DEPTH     = rfrl_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS     = rfrl_pkg::DEF_SAMPLE_BITS,
    parameter int PHASE_FRAC_BITS = rfrl_pkg::DEF_PHASE_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [PHASE_FRAC_BITS+1:0]       cfg_wr_data,
    input  logic                             src_valid,
    output logic                             src_stall,
    input  logic                             mode,
    input  logic signed [SAMPLE_BITS-1:0]    sample_in,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic signed [SAMPLE_BITS-1:0]    sample_out
);
    import rfrl_pkg::*;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int STEP_W = PHASE_FRAC_BITS + 2;
    localparam int SUM_W  = PHASE_FRAC_BITS + 3;
    localparam int CNT_W  = SUM_W - PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_RESET =
        STEP_W'((64'(SRC_RATE_HZ) << PHASE_FRAC_BITS) / 64'(OUT_RATE_HZ));
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CONSUME,
        S_PEEK,
        S_MUL,
        S_OUT
    } state_t;

    state_t                        state_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic [IDX_W-1:0]              wr_idx_reg;
    logic signed [SAMPLE_BITS-1:0] held_reg;
    logic [PHASE_FRAC_BITS-1:0]    frac_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] res_data_reg;

    logic                          src_accept;
    logic                          store_empty;
    logic [IDX_W-1:0]              rd_idx_inc;
    logic [IDX_W-1:0]              wr_idx_inc;
    logic [SUM_W-1:0]              phase_sum;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] interp_result;
    logic                          out_slot_free;
    interp_ctrl_t                  ictrl;

    // Handshake and index arithmetic
    assign src_stall     = (state_reg != S_IDLE);
    assign src_accept    = src_valid && !src_stall;
    assign store_empty   = (rd_idx_reg == wr_idx_reg);
    assign rd_idx_inc    = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
    assign wr_idx_inc    = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign phase_sum     = SUM_W'(frac_reg) + SUM_W'(step_reg);
    assign out_slot_free = !res_valid_reg || !res_stall;

    // Datapath steering
    always_comb
    begin
        ictrl           = '0;
        ictrl.load_diff = (state_reg == S_PEEK);
        ictrl.use_held  = store_empty;
        ictrl.load_prod = (state_reg == S_MUL);
    end

    // Ring memory
    rfrl_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (src_accept && !mode),
        .wr_addr (wr_idx_reg),
        .wr_data (sample_in),
        .rd_en   (state_reg == S_STEP),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // Interpolation
    rfrl_interp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_interp (
        .clk         (clk),
        .ctrl        (ictrl),
        .next_sample (rd_data),
        .held_sample (held_reg),
        .phase_frac  (frac_reg),
        .result      (interp_result)
    );

    // Sequencer, indexes, phase and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            held_reg      <= '0;
            frac_reg      <= '0;
            step_reg      <= STEP_RESET;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end

            // word taken; in the output step the slot is refilled below
            if (res_valid_reg && !res_stall && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (src_accept)
                    begin
                        if (!mode)
                        begin
                            // push; a full ring drops its oldest word
                            wr_idx_reg <= wr_idx_inc;
                            if (wr_idx_inc == rd_idx_reg)
                            begin
                                rd_idx_reg <= rd_idx_inc;
                            end
                        end
                        else
                        begin
                            frac_reg  <= phase_sum[PHASE_FRAC_BITS-1:0];
                            count_reg <= phase_sum[SUM_W-1:PHASE_FRAC_BITS];
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_STEP:
                begin
                    // read at rd_idx is issued in this cycle
                    if (count_reg != '0 && !store_empty)
                    begin
                        state_reg <= S_CONSUME;
                    end
                    else
                    begin
                        state_reg <= S_PEEK;
                    end
                end
                S_CONSUME:
                begin
                    held_reg   <= rd_data;
                    rd_idx_reg <= rd_idx_inc;
                    count_reg  <= count_reg - 1'b1;
                    state_reg  <= S_STEP;
                end
                S_PEEK:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_slot_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_data_reg  <= interp_result;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign sample_out = res_data_reg;

    // A push always leaves at least one sample in the ring
    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (src_accept && !mode) |=> (rd_idx_reg != wr_idx_reg))
        else $error("ring empty after push");

    // Consumption only ever reads a stored sample
    a_consume_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONSUME) |-> (rd_idx_reg != wr_idx_reg))
        else $error("consumed from an empty ring");

    // A new result word only comes from the final sequencer step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result word raised outside the output step");

    // The ring indexes only move while idle or consuming
    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PEEK) || (state_reg == S_MUL) || (state_reg == S_OUT))
        |=> ($stable(rd_idx_reg) && $stable(wr_idx_reg)))
        else $error("ring index moved during interpolation");

endmodule

### tb/rfrl_tb_pkg.sv
`timescale 1ns / 1ps
// Codes for the source word mode, shared by the resampler checker and testbench top.
// No dependencies.
package rfrl_tb_pkg;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_TICK = 1'b1
    } word_mode_t;

endpackage

### tb/ring_fifo_linear_resampler_checker.sv
`timescale 1ns / 1ps
// Checker for ring_fifo_linear_resampler_unit: follows the step register and both channels,
// predicts each tick's interpolated word and compares. Depends on rfrl_pkg and rfrl_tb_pkg.
module ring_fifo_linear_resampler_checker #(
    parameter int STORE_DEPTH     = rfrl_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS     = rfrl_pkg::DEF_SAMPLE_BITS,
    parameter int PHASE_FRAC_BITS = rfrl_pkg::DEF_PHASE_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [PHASE_FRAC_BITS+1:0]    cfg_wr_data,
    input  logic                          src_valid,
    input  logic                          src_stall,
    input  logic                          mode,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_out,
    output int                            fail_count,
    output int                            pending
);
    import rfrl_tb_pkg::*;

    // Step after reset: source rate over output rate in Q2.16
    localparam logic [PHASE_FRAC_BITS+1:0] STEP_AT_RESET = (PHASE_FRAC_BITS+2)'(
        (longint'(rfrl_pkg::SRC_RATE_HZ) << PHASE_FRAC_BITS) / rfrl_pkg::OUT_RATE_HZ);

    // Own copy of the resampler state
    logic signed [SAMPLE_BITS-1:0] ring [STORE_DEPTH];
    int                            rd_idx;
    int                            wr_idx;
    logic signed [SAMPLE_BITS-1:0] held;
    logic [PHASE_FRAC_BITS-1:0]    phase_frac;
    logic [PHASE_FRAC_BITS+1:0]    phase_step;

    // Interpolated words still to come out, oldest first
    logic signed [SAMPLE_BITS-1:0] expected_samples [$];
    logic signed [SAMPLE_BITS-1:0] want;

    function automatic int ring_next(input int i);
        return (i + 1) % STORE_DEPTH;
    endfunction

    // Push: a full ring loses its oldest sample
    function automatic void store_sample(input logic signed [SAMPLE_BITS-1:0] s);
        ring[wr_idx] = s;
        wr_idx = ring_next(wr_idx);
        if (wr_idx == rd_idx)
            rd_idx = ring_next(rd_idx);
    endfunction

    // Tick: step the phase, consume whole samples while any are left, then blend
    function automatic logic signed [SAMPLE_BITS-1:0] interpolate_tick();
        logic [PHASE_FRAC_BITS+2:0]    phase_sum;
        int                            advance;
        logic signed [SAMPLE_BITS-1:0] next_sample;
        longint                        prod;
        longint                        mixed;
        phase_sum = phase_frac + phase_step;
        advance = int'(phase_sum >> PHASE_FRAC_BITS);
        phase_frac = phase_sum[PHASE_FRAC_BITS-1:0];
        for (int k = 0; k < advance && rd_idx != wr_idx; k++)
        begin
            held = ring[rd_idx];
            rd_idx = ring_next(rd_idx);
        end
        // empty store: the held sample stands in for the next one
        next_sample = (rd_idx != wr_idx) ? ring[rd_idx] : held;
        prod = (longint'(next_sample) - longint'(held)) * longint'(phase_frac);
        // arithmetic shift rounds toward minus infinity
        mixed = longint'(held) + (prod >>> PHASE_FRAC_BITS);
        return mixed[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Result checked before a new word is taken in: a tick never answers on its own edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx = 0;
            wr_idx = 0;
            held = '0;
            phase_frac = '0;
            phase_step = STEP_AT_RESET;
            expected_samples.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                phase_step = cfg_wr_data;
            if (res_valid && !res_stall)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("sample_out %0d with no tick waiting",
                                              sample_out));
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  sample_out, want));
                end
            end
            if (src_valid && !src_stall)
            begin
                if (mode == MODE_PUSH)
                    store_sample(sample_in);
                else
                    expected_samples.push_back(interpolate_tick());
            end
            pending <= expected_samples.size();
        end
    end

endmodule

### tb/ring_fifo_linear_resampler_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for ring_fifo_linear_resampler_unit: clock, reset, push and tick stimulus,
// step register writes and the verdict. Depends on rfrl_pkg, rfrl_tb_pkg and the checker.
module ring_fifo_linear_resampler_unit_tb;
    import rfrl_tb_pkg::*;

    localparam int SW          = rfrl_pkg::DEF_SAMPLE_BITS;
    localparam int FB          = rfrl_pkg::DEF_PHASE_FRAC_BITS;
    localparam int STOCK_WORDS = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 20;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 82;

    localparam logic [FB+1:0]        STEP_MAX   = '1;
    localparam logic [FB+1:0]        STEP_UNITY = {2'b01, {FB{1'b0}}};
    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [FB+1:0]        cfg_wr_data  = '0;
    logic                 src_valid    = 1'b0;
    logic                 src_stall;
    logic                 mode         = MODE_PUSH;
    logic signed [SW-1:0] sample_in    = '0;
    logic                 res_valid;
    logic                 res_stall    = 1'b0;
    logic signed [SW-1:0] sample_out;
    logic                 hold_results = 1'b0;
    int                   src_idle_pct = 0;
    int                   res_stall_pct = 0;
    int                   fail_count;
    int                   pending;

    always #2 clk = ~clk;

    ring_fifo_linear_resampler_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .mode        (mode),
        .sample_in   (sample_in),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .sample_out  (sample_out)
    );

    ring_fifo_linear_resampler_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .mode        (mode),
        .sample_in   (sample_in),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .sample_out  (sample_out),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Receiver: random stalls, or a solid hold-off while hold_results is set
    always @(posedge clk)
    begin
        if (hold_results)
            res_stall <= 1'b1;
        else
            res_stall <= ($urandom_range(99) < res_stall_pct);
    end

    // Mostly full-range samples, with the two extremes now and then
    function automatic logic signed [SW-1:0] draw_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic set_idling(input idle_profile_t profile);
        src_idle_pct  = (profile == IDLE_SENDER)   ? 61 :
                        (profile == IDLE_BOTH)     ? 31 : 0;
        res_stall_pct = (profile == IDLE_RECEIVER) ? 61 :
                        (profile == IDLE_BOTH)     ? 31 : 0;
    endtask

    // Offer one word after any idle cycles; returns on the edge that takes it
    task automatic send_word(input word_mode_t m, input logic signed [SW-1:0] s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            mode      <= 1'($urandom);
            sample_in <= SW'($urandom);
            @(posedge clk);
        end
        src_valid <= 1'b1;
        mode      <= m;
        sample_in <= s;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    // Sender quiet until every tick has answered, then a settling wait for a last push
    task automatic drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_step(input logic [FB+1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic hold_off();
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    endtask

    task automatic run_words(input int count, input int push_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < push_pct)
                send_word(MODE_PUSH, draw_sample());
            else
                send_word(MODE_TICK, SW'($urandom));
        end
    endtask

    // Run limit
    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [FB+1:0] phase_steps [PHASES];
        int            step_val;
        int            push_pct;

        phase_steps = '{STEP_UNITY, STEP_UNITY + (STEP_UNITY >> 1), 18'd98304, STEP_MAX,
                        18'd1, 18'd0, STEP_UNITY >> 1, 18'd0, 18'd0, 18'd200000};
        phase_steps[7] = (FB+2)'($urandom_range(STEP_MAX, 1));
        phase_steps[8] = (FB+2)'($urandom_range(STEP_MAX, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step, empty store: the tick repeats the cleared held sample
        send_word(MODE_TICK, SW'($urandom));
        send_word(MODE_PUSH, SAMPLE_MAX);
        send_word(MODE_PUSH, SAMPLE_MIN);
        send_word(MODE_PUSH, '0);
        send_word(MODE_PUSH, '1);
        repeat (5) send_word(MODE_TICK, SW'($urandom));

        // Widest step: the store runs dry part way through a tick
        write_step(STEP_MAX);
        send_word(MODE_PUSH, SAMPLE_MIN);
        send_word(MODE_PUSH, SAMPLE_MAX);
        repeat (2) send_word(MODE_TICK, SW'($urandom));

        // Zero step: phase frozen, nothing consumed
        write_step('0);
        send_word(MODE_PUSH, 16'sd777);
        send_word(MODE_TICK, SW'($urandom));
        write_step(18'd1);
        send_word(MODE_TICK, SW'($urandom));

        // Unity step: one sample per tick, then ticks on an empty store
        write_step(STEP_UNITY);
        send_word(MODE_PUSH, SAMPLE_MAX);
        send_word(MODE_PUSH, SAMPLE_MIN);
        repeat (3) send_word(MODE_TICK, SW'($urandom));

        // Random phases; pushes track the step so the store neither floods nor starves
        for (int p = 0; p < PHASES; p++)
        begin
            write_step(phase_steps[p]);
            set_idling(idle_profile_t'(p % 4));
            step_val = int'(phase_steps[p]);
            push_pct = 20 + (60 * step_val) / (step_val + int'(STEP_UNITY));
            if (p == 2)
            begin
                // long receiver hold-off with the sender still offering words
                fork
                    hold_off();
                    run_words(PHASE_WORDS, push_pct);
                join
            end
            else
                run_words(PHASE_WORDS, push_pct);
        end

        // Stock the ring with the phase frozen, then drain it with wide steps
        write_step('0);
        set_idling(IDLE_NONE);
        repeat (STOCK_WORDS) send_word(MODE_PUSH, draw_sample());
        repeat (4) send_word(MODE_TICK, SW'($urandom));
        write_step(STEP_MAX);
        set_idling(IDLE_BOTH);
        repeat (20) send_word(MODE_TICK, SW'($urandom));

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
